// ===== design/ssd_pkg.sv =====
// shared constants for the ssd patch nearest match block
`default_nettype none
package ssd_pkg;
  localparam int MAX_WIDTH_DEF    = 64;
  localparam int MAX_HEIGHT_DEF   = 64;
  localparam int MAX_RADIUS_DEF   = 7;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DIST_W     = 26;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd3;
  localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_SAT  = {{(DIST_W-1){1'b1}}, 1'b0};
endpackage
`default_nettype wire

// ===== design/ssd_patch_nearest_match_unit.sv =====
// top level: pixel store and sequential ssd block matching search
// Usage: configure image_width, image_height, patch_radius and grid_stride
// through the cfg_ write port while the block is idle. Input words with
// in_opcode 0 load one pixel into the pixel store and give no output word,
// so loads can follow back to back. A word with in_opcode 1 queries the
// patch at (in_col, in_row) and yields one output word. The grid check
// first subtracts the stride from both corner coordinates, one step per
// cycle. An off-grid or out-of-image query then gives a not-matched word,
// registered in the check state. A valid query walks every candidate corner
// in raster order; for each pixel of a candidate it reads the query pixel,
// then the candidate pixel, then sums the three channels one after another
// (one shared store read port and one squared-difference unit), and each
// candidate ends in a compare step; the query patch itself skips its sum and
// goes straight to the compare step. in_stall is high while a query is
// running or an output word waits. When the receiver stalls, out_valid and
// the output payload hold until taken. Reset clears control and
// configuration to defaults; the pixel store is not cleared, and queries
// must only touch loaded pixels.
`default_nettype none
module ssd_patch_nearest_match_unit #(
  parameter int MAX_WIDTH    = ssd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = ssd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS   = ssd_pkg::MAX_RADIUS_DEF,
  parameter int CHANNEL_BITS = ssd_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_opcode,
  input  wire logic [5:0]                      in_col,
  input  wire logic [5:0]                      in_row,
  input  wire logic [7:0]                      in_chan_a,
  input  wire logic [7:0]                      in_chan_b,
  input  wire logic [7:0]                      in_chan_c,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_matched,
  output logic [5:0]                           out_best_col,
  output logic [5:0]                           out_best_row,
  output logic signed [6:0]                    out_shift_col,
  output logic signed [6:0]                    out_shift_row,
  output logic [ssd_pkg::DIST_W-1:0]           out_least_distance
);
  import ssd_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int XCW   = $clog2(MAX_WIDTH + 1);
  localparam int YCW   = $clog2(MAX_HEIGHT + 1);
  localparam int AW    = XW + YW;
  localparam int PW    = 3 * CHANNEL_BITS;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int SW    = RW + 1;
  localparam int SQW   = 2 * CHANNEL_BITS;
  localparam int ACCW  = DIST_W + 1;
  localparam int SUMW  = ((ACCW > SQW) ? ACCW : SQW) + 1;
  localparam logic [CHANNEL_BITS-1:0] CMASK = {CHANNEL_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_CHECK, ST_RDQ, ST_RDC, ST_SUM, ST_NEXT, ST_OUT
  } state_t;

  state_t state_r;
  logic [6:0] width_r, height_r, stride_r;
  logic [2:0] radius_r;
  logic [XW-1:0] qc_r, cc_r;
  logic [YW-1:0] qr_r, cr_r;
  logic [SW-1:0] dx_r, dy_r, side_r;
  logic [XCW-1:0] wuse_r;
  logic [YCW-1:0] huse_r;
  logic [PW-1:0] qpix_r;
  logic [1:0] ch_r;
  logic [ACCW-1:0] acc_r;
  logic found_r;
  logic [DIST_W-1:0] best_r;
  logic [XW-1:0] bc_r;
  logic [YW-1:0] br_r;
  logic [PW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic [6:0] qcm_r, qrm_r;
  logic [6:0] remc_r, remr_r, strq_r;
  logic [6:0] stride_eff;

  // effective config values
  logic [XCW-1:0] w_eff;
  logic [YCW-1:0] h_eff;
  logic [RW-1:0]  r_eff;
  always_comb begin
    w_eff = (32'(width_r) > MAX_WIDTH) ? XCW'(MAX_WIDTH) : XCW'(width_r);
    h_eff = (32'(height_r) > MAX_HEIGHT) ? YCW'(MAX_HEIGHT) : YCW'(height_r);
    r_eff = (32'(radius_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_r);
    stride_eff = (stride_r == 7'd0) ? 7'd1 : stride_r;
  end

  // pixel store
  logic ld_we;
  assign ld_we = in_valid && !in_stall && !in_opcode
              && (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);

  // candidate address held through the channel cycles
  always_comb begin
    if (state_r == ST_RDC || state_r == ST_SUM) begin
      raddr = {YW'(32'(cr_r) + 32'(dy_r)), XW'(32'(cc_r) + 32'(dx_r))};
    end else begin
      raddr = {YW'(32'(qr_r) + 32'(dy_r)), XW'(32'(qc_r) + 32'(dx_r))};
    end
  end

  ssd_ram #(.WIDTH(PW), .DEPTH(1 << AW)) u_store (
    .clk   (clk),
    .we    (ld_we),
    .waddr ({YW'(in_row), XW'(in_col)}),
    .wdata ({CHANNEL_BITS'(in_chan_c) & CMASK, CHANNEL_BITS'(in_chan_b) & CMASK,
             CHANNEL_BITS'(in_chan_a) & CMASK}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared squared difference unit, one channel per cycle
  logic [CHANNEL_BITS-1:0] ca, cb, cdiff;
  logic [SQW-1:0] sq;
  always_comb begin
    ca = qpix_r[ch_r*CHANNEL_BITS +: CHANNEL_BITS];
    cb = rdata[ch_r*CHANNEL_BITS +: CHANNEL_BITS];
    cdiff = (ca >= cb) ? (ca - cb) : (cb - ca);
    sq = SQW'(cdiff) * SQW'(cdiff);
  end

  // saturating accumulate
  logic [SUMW-1:0] acc_sum;
  logic [ACCW-1:0] acc_add;
  assign acc_sum = SUMW'(acc_r) + SUMW'(sq);
  assign acc_add = (acc_sum > SUMW'(DIST_SAT)) ? ACCW'(DIST_SAT) : ACCW'(acc_sum);

  logic last_dx, last_dy, last_cc, last_cr, is_query;
  assign last_dx  = (dx_r == side_r - SW'(1));
  assign last_dy  = (dy_r == side_r - SW'(1));
  assign last_cc  = (32'(cc_r) + 32'(side_r) >= 32'(wuse_r));
  assign last_cr  = (32'(cr_r) + 32'(side_r) >= 32'(huse_r));
  assign is_query = (cc_r == qc_r) && (cr_r == qr_r);

  logic [DIST_W-1:0] dist_sat;
  assign dist_sat = (acc_r > ACCW'(DIST_SAT)) ? DIST_SAT : DIST_W'(acc_r);

  assign in_stall = (state_r != ST_IDLE);

  // first candidate is the query patch itself
  function automatic logic is_query_start(logic [XW-1:0] c, logic [YW-1:0] r);
    return (c == '0) && (r == '0);
  endfunction

  // next candidate is the query patch, skip its sum
  function automatic logic next_is_query(logic wrap);
    logic [XW-1:0] nc;
    logic [YW-1:0] nr;
    nc = wrap ? '0 : cc_r + XW'(1);
    nr = wrap ? cr_r + YW'(1) : cr_r;
    return (nc == qc_r) && (nr == qr_r);
  endfunction

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      width_r   <= 7'd64;
      height_r  <= 7'd64;
      radius_r  <= 3'd1;
      stride_r  <= 7'd1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          REG_RADIUS: radius_r <= cfg_data[2:0];
          REG_STRIDE: stride_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_opcode) begin
            qc_r   <= XW'(in_col);
            qr_r   <= YW'(in_row);
            qcm_r  <= 7'(in_col);
            qrm_r  <= 7'(in_row);
            remc_r <= 7'(in_col);
            remr_r <= 7'(in_row);
            strq_r <= stride_eff;
            side_r <= SW'({r_eff, 1'b1});
            wuse_r <= w_eff;
            huse_r <= h_eff;
            state_r <= ST_MOD;
          end
        end
        // grid remainder by repeated subtraction
        ST_MOD: begin
          if (remc_r >= strq_r) begin
            remc_r <= remc_r - strq_r;
          end
          if (remr_r >= strq_r) begin
            remr_r <= remr_r - strq_r;
          end
          if (remc_r < strq_r && remr_r < strq_r) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cc_r <= '0; cr_r <= '0; dx_r <= '0; dy_r <= '0;
          acc_r <= '0; ch_r <= 2'd0; found_r <= 1'b0;
          best_r <= DIST_ONES; bc_r <= qc_r; br_r <= qr_r;
          if (remc_r != 7'd0 || remr_r != 7'd0
              || 32'(qcm_r) + 32'(side_r) > 32'(wuse_r)
              || 32'(qrm_r) + 32'(side_r) > 32'(huse_r)) begin
            out_valid <= 1'b1;
            out_matched <= 1'b0;
            out_best_col <= '0; out_best_row <= '0;
            out_shift_col <= '0; out_shift_row <= '0;
            out_least_distance <= '0;
            state_r <= ST_OUT;
          end else if (is_query_start(qc_r, qr_r)) begin
            state_r <= ST_NEXT;
          end else begin
            state_r <= ST_RDQ;
          end
        end
        ST_RDQ: begin
          state_r <= ST_RDC;
        end
        ST_RDC: begin
          qpix_r <= rdata;
          ch_r <= 2'd0;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          acc_r <= acc_add;
          if (ch_r == 2'd2) begin
            if (last_dx) begin
              dx_r <= '0;
              if (last_dy) begin
                dy_r <= '0;
                state_r <= ST_NEXT;
              end else begin
                dy_r <= dy_r + SW'(1);
                state_r <= ST_RDQ;
              end
            end else begin
              dx_r <= dx_r + SW'(1);
              state_r <= ST_RDQ;
            end
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        ST_NEXT: begin
          if (!is_query && (!found_r || dist_sat < best_r)) begin
            found_r <= 1'b1;
            best_r <= dist_sat;
            bc_r <= cc_r;
            br_r <= cr_r;
          end
          acc_r <= '0;
          if (last_cc && last_cr) begin
            out_valid <= 1'b1;
            out_matched <= 1'b1;
            state_r <= ST_OUT;
            if (!is_query && (!found_r || dist_sat < best_r)) begin
              out_best_col <= 6'(cc_r);
              out_best_row <= 6'(cr_r);
              out_shift_col <= 7'(7'(cc_r) - qcm_r);
              out_shift_row <= 7'(7'(cr_r) - qrm_r);
              out_least_distance <= dist_sat;
            end else begin
              out_best_col <= 6'(bc_r);
              out_best_row <= 6'(br_r);
              out_shift_col <= 7'(7'(bc_r) - qcm_r);
              out_shift_row <= 7'(7'(br_r) - qrm_r);
              out_least_distance <= best_r;
            end
          end else begin
            if (last_cc) begin
              cc_r <= '0;
              cr_r <= cr_r + YW'(1);
            end else begin
              cc_r <= cc_r + XW'(1);
            end
            state_r <= next_is_query(last_cc) ? ST_NEXT : ST_RDQ;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/ssd_ram.sv =====
// generic ram with one write port and one registered read port
`default_nettype none
module ssd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== verif/ssd_patch_nearest_match_unit_tb.sv =====
// testbench for the ssd patch nearest match unit: pixel loads and patch queries
module ssd_patch_nearest_match_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssd_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int STORE_W     = 64;

  typedef struct packed {
    logic              matched;
    logic [5:0]        best_col;
    logic [5:0]        best_row;
    logic signed [6:0] shift_col;
    logic signed [6:0] shift_row;
    logic [DIST_W-1:0] least_distance;
  } match_t;

  typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} op_e;

  typedef struct {
    op_e        op;
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    bit         known;
    match_t     res;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [5:0] in_col = '0;
  logic [5:0] in_row = '0;
  logic [7:0] in_chan_a = '0;
  logic [7:0] in_chan_b = '0;
  logic [7:0] in_chan_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_matched;
  logic [5:0] out_best_col;
  logic [5:0] out_best_row;
  logic signed [6:0] out_shift_col;
  logic signed [6:0] out_shift_row;
  logic [DIST_W-1:0] out_least_distance;

  ssd_patch_nearest_match_unit dut (.*);

  always #2 clk = ~clk;

  // shadow image and configuration
  bit [23:0] shadow_pix [STORE_W*STORE_W];
  int img_w = 64, img_h = 64, img_r = 1, img_s = 1;
  match_t pending_matches [$];
  int send_pct = 0, stall_pct = 0;
  int mismatches = 0, idle_cycles = 0, queries_seen = 0, matched_seen = 0;

  function automatic longint patch_dist(int qc, int qr, int cc, int cr, int side);
    longint sum;
    int d;
    sum = 0;
    for (int dy = 0; dy < side; dy++)
      for (int dx = 0; dx < side; dx++)
        for (int k = 0; k < 3; k++) begin
          d = int'(shadow_pix[(qr+dy)*STORE_W+qc+dx][8*k +: 8])
            - int'(shadow_pix[(cr+dy)*STORE_W+cc+dx][8*k +: 8]);
          sum += d * d;
        end
    return sum;
  endfunction

  // exhaustive raster search, first strictly least distance wins
  function automatic match_t search_best(int qc, int qr);
    int w, h, r, s, side, bc, br;
    longint best, d;
    bit found;
    match_t m;
    m = '0;
    w = img_w > 64 ? 64 : img_w;
    h = img_h > 64 ? 64 : img_h;
    r = img_r > 7 ? 7 : img_r;
    s = img_s == 0 ? 1 : img_s;
    side = 2 * r + 1;
    if (qc % s != 0 || qr % s != 0 || qc + side > w || qr + side > h) return m;
    best = DIST_ONES;
    bc = qc;
    br = qr;
    found = 0;
    for (int cr = 0; cr + side <= h; cr++)
      for (int cc = 0; cc + side <= w; cc++) begin
        if (cc == qc && cr == qr) continue;
        d = patch_dist(qc, qr, cc, cr, side);
        if (d > DIST_SAT) d = DIST_SAT;
        if (!found || d < best) begin
          found = 1;
          best = d;
          bc = cc;
          br = cr;
        end
      end
    m.matched = 1'b1;
    m.best_col = bc[5:0];
    m.best_row = br[5:0];
    m.shift_col = 7'(bc - qc);
    m.shift_row = 7'(br - qr);
    m.least_distance = best[DIST_W-1:0];
    return m;
  endfunction

  // send one word, update the shadow image and queue the expected match on acceptance
  task automatic send_word(step_t st);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= st.op;
    in_col <= st.col;
    in_row <= st.row;
    in_chan_a <= st.a;
    in_chan_b <= st.b;
    in_chan_c <= st.c;
    do @(posedge clk); while (in_stall);
    if (st.op == OP_LOAD) begin
      shadow_pix[st.row*STORE_W+st.col] = {st.c, st.b, st.a};
    end else begin
      pending_matches.push_back(st.known ? st.res : search_best(st.col, st.row));
    end
  endtask

  function automatic step_t load_step(int c, int r);
    step_t st;
    st = '{OP_LOAD, 6'(c), 6'(r), 8'($urandom), 8'($urandom), 8'($urandom), 0, '0};
    return st;
  endfunction

  // write all registers while idle, then fill the image area
  task automatic start_phase(int w, int h, int r, int s, int mode);
    step_t st;
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;  cfg_data <= 7'(w); @(posedge clk);
    cfg_index <= REG_HEIGHT; cfg_data <= 7'(h); @(posedge clk);
    cfg_index <= REG_RADIUS; cfg_data <= 7'(r); @(posedge clk);
    cfg_index <= REG_STRIDE; cfg_data <= 7'(s); @(posedge clk);
    cfg_we <= 1'b0;
    img_w = w; img_h = h; img_r = r; img_s = s;
    send_pct = (mode == 1) ? 72 : (mode == 3) ? 17 : 0;
    stall_pct = (mode == 2) ? 72 : (mode == 3) ? 17 : 0;
    for (int y = 0; y < (h > 64 ? 64 : h); y++)
      for (int x = 0; x < (w > 64 ? 64 : w); x++) begin
        st = load_step(x, y);
        send_word(st);
      end
  endtask

  // random mix of loads anywhere in the store and queries mostly inside the image
  task automatic random_words(int n);
    step_t st;
    int w, h, s;
    w = img_w > 64 ? 64 : img_w;
    h = img_h > 64 ? 64 : img_h;
    s = img_s == 0 ? 1 : img_s;
    for (int i = 0; i < n; i++) begin
      st = load_step($urandom_range(63), $urandom_range(63));
      if ($urandom_range(99) < 35) begin
        st.op = OP_QUERY;
        if (w > 0 && h > 0 && $urandom_range(99) < 80) begin
          st.col = 6'($urandom_range(w - 1));
          st.row = 6'($urandom_range(h - 1));
          if ($urandom_range(1)) begin
            st.col = 6'(st.col - st.col % s);
            st.row = 6'(st.row - st.row % s);
          end
        end
      end else if ($urandom_range(1) && w > 0 && h > 0) begin
        // keep loads inside the image half the time so matches shift around
        st.col = 6'($urandom_range(w - 1));
        st.row = 6'($urandom_range(h - 1));
      end
      send_word(st);
    end
  endtask

  // result check, receiver stall and watchdog
  always @(posedge clk) begin
    match_t got, want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("[ssd_patch_nearest_match_unit] ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{out_matched, out_best_col, out_best_row, out_shift_col, out_shift_row,
                out_least_distance};
        queries_seen++;
        if (out_matched) matched_seen++;
        if (pending_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %p", got);
        end else begin
          want = pending_matches.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  step_t directed [] ;
  match_t none_found;

  initial begin
    none_found = '0;
    directed = '{
      '{OP_QUERY, 6'd63, 6'd63, 8'd0,   8'd0,   8'd0,   1, none_found},
      '{OP_QUERY, 6'd5,  6'd0,  8'd255, 8'd255, 8'd255, 1, none_found},
      '{OP_QUERY, 6'd0,  6'd4,  8'd0,   8'd0,   8'd0,   1, none_found},
      '{OP_QUERY, 6'd4,  6'd3,  8'd0,   8'd0,   8'd0,   0, none_found},
      '{OP_QUERY, 6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   0, none_found},
      '{OP_LOAD,  6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   0, none_found},
      '{OP_LOAD,  6'd1,  6'd0,  8'd255, 8'd255, 8'd255, 0, none_found},
      '{OP_QUERY, 6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   0, none_found},
      '{OP_QUERY, 6'd1,  6'd0,  8'd0,   8'd0,   8'd0,   0, none_found},
      '{OP_LOAD,  6'd63, 6'd63, 8'd255, 8'd255, 8'd255, 0, none_found},
      '{OP_LOAD,  6'd2,  6'd1,  8'd10,  8'd20,  8'd30,  0, none_found},
      '{OP_LOAD,  6'd0,  6'd2,  8'd10,  8'd20,  8'd30,  0, none_found},
      '{OP_LOAD,  6'd3,  6'd3,  8'd10,  8'd20,  8'd30,  0, none_found},
      '{OP_QUERY, 6'd3,  6'd3,  8'd0,   8'd0,   8'd0,   0, none_found},
      '{OP_QUERY, 6'd0,  6'd2,  8'd0,   8'd0,   8'd0,   0, none_found}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // not-matched query straight after reset, default configuration
    send_word(directed[0]);

    start_phase(5, 4, 0, 1, 0);
    foreach (directed[i]) send_word(directed[i]);
    random_words(25);
    start_phase(7, 6, 1, 2, 1);
    random_words(20);
    start_phase(16, 15, 7, 1, 2);
    random_words(15);
    start_phase(1, 1, 0, 64, 3);
    random_words(15);
    start_phase(127, 1, 0, 1, 0);
    random_words(20);
    start_phase(0, 0, 2, 0, 2);
    random_words(15);
    start_phase(9, 8, 2, 3, 3);
    random_words(20);

    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (pending_matches.size() != 0) mismatches++;
    $display("covered %0d queries (%0d matched) over seven image setups,",
             queries_seen, matched_seen);
    $display("radius 0 to 7, stride 1 to 64, empty and saturated image sizes");
    if (mismatches == 0) begin
      $display("[ssd_patch_nearest_match_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[ssd_patch_nearest_match_unit] ERROR");
    end
    $finish;
  end
endmodule
